### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed in %m");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed in %m");

`endif

### src/i2cmts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package i2cmts_pkg;

   localparam int DEFAULT_BUF_DEPTH = 32;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   // Input item commands.
   typedef enum logic [2:0] {
      CMD_WRITE = 3'd0,
      CMD_GO    = 3'd1,
      CMD_EVENT = 3'd2,
      CMD_TICK  = 3'd3,
      CMD_READ  = 3'd4
   } cmd_type;

   // Bus actions reported in each result item.
   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_START   = 3'd1,
      ACT_SEND    = 3'd2,
      ACT_RX_ACK  = 3'd3,
      ACT_RX_NACK = 3'd4,
      ACT_STOP    = 3'd5,
      ACT_CANCEL  = 3'd6
   } action_type;

   // Transfer phase.
   typedef enum logic [1:0] {
      PH_NONE   = 2'd0,
      PH_READY  = 2'd1,
      PH_INPROC = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   // Register indexes on the configuration port.
   typedef enum logic {
      REG_ENABLE  = 1'b0,
      REG_TIMEOUT = 1'b1
   } reg_index_type;

   // Bus status codes after masking.
   localparam logic [7:0] STATUS_MASK     = 8'hF8;
   localparam logic [7:0] ST_START        = 8'h08;
   localparam logic [7:0] ST_RSTART       = 8'h10;
   localparam logic [7:0] ST_SLAW_ACK     = 8'h18;
   localparam logic [7:0] ST_DATA_TX_ACK  = 8'h28;
   localparam logic [7:0] ST_ARB_LOST     = 8'h38;
   localparam logic [7:0] ST_SLAR_ACK     = 8'h40;
   localparam logic [7:0] ST_DATA_RX_ACK  = 8'h50;
   localparam logic [7:0] ST_DATA_RX_NACK = 8'h58;

endpackage
`default_nettype wire

### src/i2cmts_buf.sv
`timescale 1ns / 1ps
`default_nettype none
module i2cmts_buf
   import i2cmts_pkg::*;
#(
   parameter int DEPTH = DEFAULT_BUF_DEPTH,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data is held while the result it belongs to waits downstream.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### src/i2c_master_transfer_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake               Payload
// req_      in         req_tvalid/req_tready   req_tdata: command item (32 bits)
// rsp_      out        rsp_tvalid/rsp_tready   rsp_tdata: result item (24 bits)
// csr_      in/out     APB write, pready = 1   enable at 0x0, timeout_ticks at 0x4
//
// One result item is produced for every input item; it passes through the input
// register and then the result register. A new item can be taken every cycle while
// the result register is free or being emptied. The buffer is a one-write, one-read
// memory whose registered read data forms part of the result register. Reset is
// synchronous and clears all control state; the buffer is not cleared. With the
// result register full and rsp_tready low, one more item is taken into the input
// register before req_tready drops.
module i2c_master_transfer_sequencer
   import i2cmts_pkg::*;
#(
   parameter int BUF_DEPTH = DEFAULT_BUF_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // [2:0] cmd, [7:3] index, [15:8] data, [21:16] length, [29:22] bus_status,
   // [31:30] zero
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,
   // [2:0] action, [10:3] tx_byte, [18:11] read_data, [20:19] transfer_state,
   // [21] error, [22] ready_res, [23] busy_res
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [23:0] rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   // AW addresses the buffer, PW holds a position or length up to BUF_DEPTH,
   // XW is wide enough for every compare between positions, lengths and indexes.
   localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int PW = $clog2(BUF_DEPTH + 1);
   localparam int XW = (PW > 6) ? PW + 1 : 7;
   localparam logic [XW-1:0] DEPTH_X = XW'(BUF_DEPTH);

   // Input register.
   logic        s1_valid_ff;
   logic [2:0]  s1_cmd_ff;
   logic [4:0]  s1_index_ff;
   logic [7:0]  s1_data_ff;
   logic [5:0]  s1_length_ff;
   logic [7:0]  s1_status_ff;

   // Transfer state.
   logic [PW-1:0] position_ff, position_in;
   logic [PW-1:0] length_ff, length_in;
   phase_type     phase_ff, phase_in;
   logic          error_ff, error_in;
   logic          active_ff, active_in;
   logic [15:0]   countdown_ff, countdown_in;

   // Configuration registers.
   logic        enable_ff;
   logic [15:0] timeout_ff;

   // Result register; tx_byte and read_data come from the buffer read register.
   logic        rsp_valid_ff;
   action_type  action_ff;
   phase_type   tstate_ff;
   logic        rsp_error_ff;
   logic        rsp_ready_ff;
   logic        rsp_busy_ff;
   logic        tx_sel_ff;
   logic        rd_sel_ff;

   logic        advance;
   logic        csr_write;
   action_type  action_in;
   logic        tx_sel_in;
   logic        rd_sel_in;
   logic        ready_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic [AW-1:0] rd_addr;
   logic [7:0]    buf_q;

   logic [XW-1:0] index_x;
   logic          index_ok;
   logic [XW-1:0] go_len_x;
   logic [7:0]    code;
   logic          code_is_start;
   logic [PW-1:0] send_pos;
   logic          send_ok;
   logic          take_ok;
   logic [PW-1:0] pos_after_take;
   logic          rx_more;
   logic [15:0]   countdown_dec;

   // The input register moves on whenever the result register is free or being
   // emptied in the same cycle.
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_cmd_ff    <= req_tdata[2:0];
         s1_index_ff  <= req_tdata[7:3];
         s1_data_ff   <= req_tdata[15:8];
         s1_length_ff <= req_tdata[21:16];
         s1_status_ff <= req_tdata[29:22];
      end
   end

   // Helper values for the item in the input register.
   assign index_x        = XW'(s1_index_ff);
   assign index_ok       = index_x < DEPTH_X;
   assign go_len_x       = (XW'(s1_length_ff) > DEPTH_X) ? DEPTH_X : XW'(s1_length_ff);
   assign code           = s1_status_ff & STATUS_MASK;
   assign code_is_start  = (code == ST_START) || (code == ST_RSTART);
   assign send_pos       = code_is_start ? '0 : position_ff;
   assign send_ok        = (XW'(send_pos) < XW'(length_ff)) && (XW'(send_pos) < DEPTH_X);
   assign take_ok        = (XW'(position_ff) < XW'(length_ff))
                           && (XW'(position_ff) < DEPTH_X);
   assign pos_after_take = take_ok ? position_ff + PW'(1) : position_ff;
   assign rx_more        = (XW'(pos_after_take) + XW'(1)) < XW'(length_ff);
   assign countdown_dec  = (countdown_ff == '0) ? '0 : countdown_ff - 16'd1;

   // Next state for the item in the input register.
   always_comb begin
      position_in  = position_ff;
      length_in    = length_ff;
      phase_in     = phase_ff;
      error_in     = error_ff;
      active_in    = active_ff;
      countdown_in = countdown_ff;
      action_in    = ACT_NONE;
      tx_sel_in    = 1'b0;
      rd_sel_in    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = AW'(index_x);
      wr_data      = s1_data_ff;
      rd_addr      = AW'(index_x);

      unique case (s1_cmd_ff)
         CMD_WRITE: begin
            wr_en = index_ok;
         end
         CMD_GO: begin
            if (enable_ff && !active_ff && (phase_ff == PH_NONE || phase_ff == PH_DONE)) begin
               length_in = PW'(go_len_x);
               if (go_len_x == '0) begin
                  active_in = 1'b0;
                  error_in  = 1'b1;
                  length_in = '0;
                  phase_in  = PH_DONE;
                  action_in = ACT_CANCEL;
               end else begin
                  position_in = '0;
                  phase_in    = PH_READY;
                  active_in   = 1'b1;
                  action_in   = ACT_START;
               end
            end
         end
         CMD_EVENT: begin
            if (active_ff) begin
               // The first event after go opens the transfer and arms the timeout.
               if (phase_ff == PH_READY) begin
                  phase_in     = PH_INPROC;
                  countdown_in = timeout_ff;
               end
               if (phase_ff != PH_READY && phase_ff != PH_INPROC) begin
                  active_in = 1'b0;
                  action_in = ACT_CANCEL;
               end else begin
                  unique case (code)
                     ST_START, ST_RSTART, ST_SLAW_ACK, ST_DATA_TX_ACK: begin
                        if (send_ok) begin
                           position_in = send_pos + PW'(1);
                           rd_addr     = send_pos[AW-1:0];
                           tx_sel_in   = 1'b1;
                           action_in   = ACT_SEND;
                        end else begin
                           position_in = send_pos;
                           error_in    = 1'b0;
                           phase_in    = PH_DONE;
                           active_in   = 1'b0;
                           action_in   = ACT_STOP;
                        end
                     end
                     ST_DATA_RX_ACK: begin
                        wr_en       = take_ok;
                        wr_addr     = position_ff[AW-1:0];
                        position_in = pos_after_take;
                        action_in   = rx_more ? ACT_RX_ACK : ACT_RX_NACK;
                     end
                     ST_SLAR_ACK: begin
                        action_in = (XW'(position_ff) + XW'(1) < XW'(length_ff))
                                    ? ACT_RX_ACK : ACT_RX_NACK;
                     end
                     ST_DATA_RX_NACK: begin
                        wr_en       = take_ok;
                        wr_addr     = position_ff[AW-1:0];
                        position_in = pos_after_take;
                        error_in    = 1'b0;
                        phase_in    = PH_DONE;
                        active_in   = 1'b0;
                        action_in   = ACT_STOP;
                     end
                     ST_ARB_LOST: begin
                        if (length_ff == '0) begin
                           active_in = 1'b0;
                           error_in  = 1'b1;
                           phase_in  = PH_DONE;
                           action_in = ACT_CANCEL;
                        end else begin
                           position_in = '0;
                           action_in   = ACT_START;
                        end
                     end
                     default: begin
                        active_in = 1'b0;
                        error_in  = 1'b1;
                        length_in = '0;
                        phase_in  = PH_DONE;
                        action_in = ACT_CANCEL;
                     end
                  endcase
               end
            end
         end
         CMD_TICK: begin
            if (enable_ff && phase_ff == PH_INPROC) begin
               countdown_in = countdown_dec;
               if (countdown_dec == '0) begin
                  active_in = 1'b0;
                  error_in  = 1'b1;
                  length_in = '0;
                  phase_in  = PH_DONE;
                  action_in = ACT_CANCEL;
               end
            end
         end
         CMD_READ: begin
            rd_sel_in = index_ok;
         end
         default: begin
         end
      endcase
   end

   // Status flags of the result, taken from the state after the item.
   assign ready_in = enable_ff && (phase_in == PH_NONE || phase_in == PH_DONE);

   i2cmts_buf #(
      .DEPTH (BUF_DEPTH),
      .AW    (AW)
   ) u_buf (
      .clock   (clock),
      .wr_en   (advance && wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (advance),
      .rd_addr (rd_addr),
      .rd_data (buf_q)
   );

   // State update. Configuration writes must only come while the block is idle; the block
   // does not enforce this, and a write wins over an advancing item's state update.
   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         length_ff    <= '0;
         phase_ff     <= PH_NONE;
         error_ff     <= 1'b0;
         active_ff    <= 1'b0;
         countdown_ff <= '0;
         enable_ff    <= 1'b0;
         timeout_ff   <= TIMEOUT_RESET;
      end else if (csr_write) begin
         unique case (reg_index_type'(csr_paddr[2]))
            REG_ENABLE: begin
               // Clearing enable drops the transfer; setting it starts afresh.
               if (!csr_pwdata[0]) begin
                  active_ff <= 1'b0;
               end else if (!enable_ff) begin
                  phase_ff  <= PH_NONE;
                  active_ff <= 1'b0;
               end
               enable_ff <= csr_pwdata[0];
            end
            REG_TIMEOUT: begin
               timeout_ff <= csr_pwdata[15:0];
            end
            default: begin
            end
         endcase
      end else if (advance) begin
         position_ff  <= position_in;
         length_ff    <= length_in;
         phase_ff     <= phase_in;
         error_ff     <= error_in;
         active_ff    <= active_in;
         countdown_ff <= countdown_in;
      end
   end

   always_comb begin
      unique case (reg_index_type'(csr_paddr[2]))
         REG_ENABLE:  csr_prdata = {31'd0, enable_ff};
         REG_TIMEOUT: csr_prdata = {16'd0, timeout_ff};
         default:     csr_prdata = '0;
      endcase
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         action_ff    <= action_in;
         tstate_ff    <= phase_in;
         rsp_error_ff <= error_in;
         rsp_ready_ff <= ready_in;
         rsp_busy_ff  <= active_in;
         tx_sel_ff    <= tx_sel_in;
         rd_sel_ff    <= rd_sel_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_busy_ff,
                        rsp_ready_ff,
                        rsp_error_ff,
                        tstate_ff,
                        rd_sel_ff ? buf_q : 8'd0,
                        tx_sel_ff ? buf_q : 8'd0,
                        action_ff};

endmodule
`default_nettype wire

### src/i2cmts_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module i2cmts_checker
   import i2cmts_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);

   logic [2:0] r_action;
   logic [7:0] r_tx_byte;
   logic [1:0] r_state;
   logic       r_error;
   logic       r_busy;

   assign r_action  = rsp_tdata[2:0];
   assign r_tx_byte = rsp_tdata[10:3];
   assign r_state   = rsp_tdata[20:19];
   assign r_error   = rsp_tdata[21];
   assign r_busy    = rsp_tdata[23];

   // A result that is not taken stays on the bus unchanged.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // A running sequence is always in the ready or in-process phase.
   `ASSERT_IMPL(a_busy_phase, clock, reset, rsp_tvalid && r_busy, r_state == PH_READY || r_state == PH_INPROC)

   // STOP ends the transfer cleanly.
   `ASSERT_IMPL(a_stop_clean, clock, reset, rsp_tvalid && r_action == ACT_STOP, !r_error && !r_busy && r_state == PH_DONE)

   // Only a send carries a transmit byte.
   `ASSERT_IMPL(a_tx_only_send, clock, reset, rsp_tvalid && r_tx_byte != 8'd0, r_action == ACT_SEND)

endmodule

bind i2c_master_transfer_sequencer i2cmts_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
